### design/stlr_pkg.sv
package stlr_pkg;

	// table geometry
	localparam int SLOTS    = 8;
	localparam int KEY_BITS = 64;
	localparam int TS_W     = 32;
	localparam int WIN_W    = 16;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int ENTRY_W  = KEY_BITS + TS_W;

	// result field widths
	localparam int OUT_SLOT_W  = 3;
	localparam int OUT_COUNT_W = 4;

	// item modes
	localparam logic MODE_ACCESS  = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// register indexes (word address bit 2)
	localparam logic REG_ONLINE_WIN  = 1'b0;
	localparam logic REG_RELOGIN_WIN = 1'b1;

	// register reset values
	localparam logic [WIN_W-1:0] ONLINE_WIN_RST  = 16'd900;
	localparam logic [WIN_W-1:0] RELOGIN_WIN_RST = 16'd60;

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [SLOTS-1:0]  slot_vec_t;

	// slot index as reported: low three bits
	function automatic logic [OUT_SLOT_W-1:0] slot_out(input slot_idx_t idx);
		logic [SLOT_W+OUT_SLOT_W-1:0] wide;
		wide = {{OUT_SLOT_W{1'b0}}, idx};
		return wide[OUT_SLOT_W-1:0];
	endfunction

	// population count of a slot vector, saturated to the result width
	function automatic logic [OUT_COUNT_W-1:0] count_sat(input slot_vec_t v);
		logic [CNT_W+OUT_COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < SLOTS; i++) begin
			n = n + (CNT_W + OUT_COUNT_W)'(v[i]);
		end
		if (n > (CNT_W + OUT_COUNT_W)'((1 << OUT_COUNT_W) - 1)) begin
			return {OUT_COUNT_W{1'b1}};
		end
		return n[OUT_COUNT_W-1:0];
	endfunction

endpackage

### design/stlr_ifs.sv
// request channel: one access or release item
interface stlr_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [stlr_pkg::KEY_BITS-1:0] user_key;
	logic [stlr_pkg::TS_W-1:0]     now_secs;
	logic                          admin;
	logic                          user_known;

	modport source (output valid, mode, user_key, now_secs, admin, user_known, input ready);
	modport sink   (input valid, mode, user_key, now_secs, admin, user_known, output ready);
endinterface

// response channel: one result per item
interface stlr_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [stlr_pkg::OUT_SLOT_W-1:0]  slot;
	logic                             hit;
	logic                             evicted;
	logic                             fast_rejoin;
	logic [stlr_pkg::OUT_COUNT_W-1:0] online_count;

	modport source (output valid, slot, hit, evicted, fast_rejoin, online_count, input ready);
	modport sink   (input valid, slot, hit, evicted, fast_rejoin, online_count, output ready);
endinterface

### design/stlr_ram.sv
module stlr_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 96
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/session_table_lru_replace.sv
// Channel  Dir  Transfer when           Payload
// req      in   req.valid & req.ready   mode, user_key, now_secs, admin, user_known
// rsp      out  rsp.valid & rsp.ready   slot, hit, evicted, fast_rejoin, online_count
// apb      in   psel & penable & pwrite online_window_secs (0x0), relogin_window_secs (0x4)
//
// An item passes through the transfer, one read of the key/stamp memory per slot, the
// registered read data of the last slot, and a write-back.
// Reset clears all slot flags and loads the window registers; the memory is not cleared.
// req.ready is high only between items; a result held in the output register
// does not block the next item, but write-back waits until that register is free.
module session_table_lru_replace (
	input  logic                 clk,
	input  logic                 arst_n,
	stlr_req_if.sink             req,
	stlr_rsp_if.source           rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	localparam int KB = stlr_pkg::KEY_BITS;
	localparam int TW = stlr_pkg::TS_W;
	localparam int SW = stlr_pkg::SLOT_W;

	logic [1:0] state_q;

	// configuration
	logic [stlr_pkg::WIN_W-1:0] online_win_q;
	logic [stlr_pkg::WIN_W-1:0] relogin_win_q;

	// latched item
	logic          mode_q;
	logic [KB-1:0] key_q;
	logic [TW-1:0] now_q;
	logic          admin_q;
	logic          known_q;

	// slot flags
	stlr_pkg::slot_vec_t act_q;
	stlr_pkg::slot_vec_t sys_q;
	stlr_pkg::slot_vec_t reg_q;

	// scan control
	logic [SW:0]         cnt_q;
	logic                rd_vld_s1;
	stlr_pkg::slot_idx_t rd_idx_s1;

	// scan results
	logic                match_q;
	stlr_pkg::slot_idx_t match_idx_q;
	logic [TW-1:0]       match_stamp_q;
	logic                match_reg_q;
	logic                match_sys_q;
	logic                free_q;
	stlr_pkg::slot_idx_t free_idx_q;
	logic                vic_q;
	stlr_pkg::slot_idx_t vic_idx_q;
	logic [TW-1:0]       vic_stamp_q;
	stlr_pkg::slot_vec_t online_q;

	// output register
	logic                                 out_vld_q;
	logic [stlr_pkg::OUT_SLOT_W-1:0]      out_slot_q;
	logic                                 out_hit_q;
	logic                                 out_evict_q;
	logic                                 out_quick_q;
	logic [stlr_pkg::OUT_COUNT_W-1:0]     out_count_q;

	// memory signals
	logic                          mem_we;
	stlr_pkg::slot_idx_t           mem_raddr;
	logic [stlr_pkg::ENTRY_W-1:0]  mem_rdata;
	logic [KB-1:0]                 rd_key;
	logic [TW-1:0]                 rd_stamp;
	logic [TW-1:0]                 rd_age;

	// write-back decision
	logic                req_xfer;
	logic                wb_go;
	stlr_pkg::slot_idx_t wb_slot;
	logic                wb_hit;
	logic                wb_evict;
	logic                wb_quick;
	logic                wb_flags;
	logic                wb_act;
	logic                wb_sys;
	logic                wb_reg;
	stlr_pkg::slot_vec_t act_n;
	stlr_pkg::slot_vec_t reg_n;
	stlr_pkg::slot_vec_t online_n;
	logic [TW-1:0]       match_age;
	logic                last_rd;
	logic                cfg_we;

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign wb_go = (state_q == ST_WRITE) && (!out_vld_q || rsp.ready);
	assign last_rd = rd_vld_s1 && (rd_idx_s1 == SW'(stlr_pkg::SLOTS - 1));

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			stlr_pkg::REG_ONLINE_WIN:  prdata = {16'b0, online_win_q};
			stlr_pkg::REG_RELOGIN_WIN: prdata = {16'b0, relogin_win_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_win_q  <= stlr_pkg::ONLINE_WIN_RST;
			relogin_win_q <= stlr_pkg::RELOGIN_WIN_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				stlr_pkg::REG_ONLINE_WIN:  online_win_q  <= pwdata[stlr_pkg::WIN_W-1:0];
				stlr_pkg::REG_RELOGIN_WIN: relogin_win_q <= pwdata[stlr_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// key and stamp memory
	assign mem_raddr = cnt_q[SW-1:0];
	assign mem_we = wb_go && (mode_q == stlr_pkg::MODE_ACCESS);

	stlr_ram #(
		.DEPTH(stlr_pkg::SLOTS),
		.WIDTH(stlr_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wb_slot),
		.wdata ({key_q, now_q}),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_key   = mem_rdata[stlr_pkg::ENTRY_W-1:TW];
	assign rd_stamp = mem_rdata[TW-1:0];
	assign rd_age   = now_q - rd_stamp;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && (cnt_q < (SW + 1)'(stlr_pkg::SLOTS));
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req_xfer) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q < (SW + 1)'(stlr_pkg::SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (last_rd) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read index: the read address, registered alongside the memory read
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[SW-1:0];
	end

	// latch the item
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			mode_q  <= req.mode;
			key_q   <= req.user_key;
			now_q   <= req.now_secs;
			admin_q <= req.admin;
			known_q <= req.user_known;
		end
	end

	// walk the slots: match, first free slot, oldest unpinned slot, online marks
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			vic_q   <= 1'b0;
		end else if (rd_vld_s1) begin
			if (act_q[rd_idx_s1] && (rd_key == key_q) && !match_q) begin
				match_q       <= 1'b1;
				match_idx_q   <= rd_idx_s1;
				match_stamp_q <= rd_stamp;
				match_reg_q   <= reg_q[rd_idx_s1];
				match_sys_q   <= sys_q[rd_idx_s1];
			end
			if (!act_q[rd_idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (act_q[rd_idx_s1] && !sys_q[rd_idx_s1] &&
			    (!vic_q || (rd_stamp < vic_stamp_q))) begin
				vic_q       <= 1'b1;
				vic_idx_q   <= rd_idx_s1;
				vic_stamp_q <= rd_stamp;
			end
			online_q[rd_idx_s1] <= (rd_age <= {16'b0, online_win_q});
		end
	end

	// decide slot, flags and result fields
	assign match_age = now_q - match_stamp_q;

	always_comb begin
		wb_slot  = '0;
		wb_hit   = 1'b0;
		wb_evict = 1'b0;
		wb_quick = 1'b0;
		wb_flags = 1'b0;
		wb_act   = 1'b0;
		wb_sys   = 1'b0;
		wb_reg   = 1'b0;
		if (mode_q == stlr_pkg::MODE_RELEASE) begin
			if (match_q) begin
				wb_slot  = match_idx_q;
				wb_hit   = 1'b1;
				wb_flags = 1'b1;
			end
		end else begin
			wb_flags = 1'b1;
			wb_act   = 1'b1;
			wb_reg   = known_q;
			if (match_q) begin
				wb_slot  = match_idx_q;
				wb_hit   = 1'b1;
				wb_quick = match_reg_q && (match_age < {16'b0, relogin_win_q});
				wb_sys   = match_sys_q || admin_q;
			end else begin
				wb_sys = admin_q;
				if (free_q) begin
					wb_slot = free_idx_q;
				end else begin
					wb_evict = 1'b1;
					if (vic_q) begin
						wb_slot = vic_idx_q;
					end
				end
			end
		end
	end

	// flag vectors after the update, for the online count
	always_comb begin
		act_n    = act_q;
		reg_n    = reg_q;
		online_n = online_q;
		if (wb_flags) begin
			act_n[wb_slot] = wb_act;
			reg_n[wb_slot] = wb_reg;
			if (wb_act) begin
				online_n[wb_slot] = 1'b1;
			end
		end
	end

	// write back the flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			sys_q <= '0;
			reg_q <= '0;
		end else if (wb_go && wb_flags) begin
			act_q[wb_slot] <= wb_act;
			sys_q[wb_slot] <= wb_sys;
			reg_q[wb_slot] <= wb_reg;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (wb_go) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_slot_q  <= stlr_pkg::slot_out(wb_slot);
			out_hit_q   <= wb_hit;
			out_evict_q <= wb_evict;
			out_quick_q <= wb_quick;
			out_count_q <= stlr_pkg::count_sat(act_n & reg_n & online_n);
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.slot          = out_slot_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.evicted       = out_evict_q;
	assign rsp.fast_rejoin   = out_quick_q;
	assign rsp.online_count  = out_count_q;

	// a new result appears only after a write-back
	a_rsp_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_WRITE))
		else $error("result raised without write-back");

	// a hit never replaces a session
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> !rsp.evicted)
		else $error("hit reported with eviction");

	// quick relogin implies a hit
	a_quick_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.fast_rejoin |-> rsp.hit)
		else $error("quick relogin without hit");

	// the scan counter never goes past the slot count
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= (SW + 1)'(stlr_pkg::SLOTS))
		else $error("scan counter out of range");

	// a write-back leaves the chosen slot's active flag in the requested state
	a_wb_flags: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go && wb_flags |=> act_q[$past(wb_slot)] == $past(wb_act))
		else $error("slot flag not written back");

endmodule

### tb/session_checker.sv
// Watches the request, response and register ports of the session table,
// keeps its own copy of the table and predicts every result in order.
module session_checker (
	input  logic        clk,
	input  logic        arst_n,
	stlr_req_if         req,
	stlr_rsp_if         rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          failures,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [stlr_pkg::OUT_SLOT_W-1:0]  slot;
		logic                             hit;
		logic                             evicted;
		logic                             fast_rejoin;
		logic [stlr_pkg::OUT_COUNT_W-1:0] online_count;
	} session_result_t;

	// shadow of the table and the window registers
	logic [stlr_pkg::KEY_BITS-1:0] tracked_key        [stlr_pkg::SLOTS];
	logic                          tracked_active     [stlr_pkg::SLOTS];
	logic                          tracked_sysop      [stlr_pkg::SLOTS];
	logic                          tracked_registered [stlr_pkg::SLOTS];
	logic [stlr_pkg::TS_W-1:0]     tracked_seen       [stlr_pkg::SLOTS];
	logic [stlr_pkg::WIN_W-1:0]    online_win;
	logic [stlr_pkg::WIN_W-1:0]    relogin_win;

	session_result_t expected_results[$];

	// apply one item to the shadow table and return the result it should give
	function automatic session_result_t predict_session_update(
		input logic                          mode,
		input logic [stlr_pkg::KEY_BITS-1:0] key,
		input logic [stlr_pkg::TS_W-1:0]     now,
		input logic                          admin,
		input logic                          known
	);
		session_result_t           r;
		int                        found;
		int                        victim;
		int                        online;
		logic [stlr_pkg::TS_W-1:0] age;
		r = '0;
		found = -1;
		for (int i = stlr_pkg::SLOTS - 1; i >= 0; i--) begin
			if (tracked_active[i] && tracked_key[i] == key) begin
				found = i;
			end
		end
		if (mode == stlr_pkg::MODE_RELEASE) begin
			if (found >= 0) begin
				tracked_active[found] = 1'b0;
				tracked_sysop[found] = 1'b0;
				tracked_registered[found] = 1'b0;
				r.slot = stlr_pkg::OUT_SLOT_W'(found);
				r.hit = 1'b1;
			end
		end else begin
			if (found >= 0) begin
				r.hit = 1'b1;
				age = now - tracked_seen[found];
				r.fast_rejoin = tracked_registered[found] &&
				                (age < stlr_pkg::TS_W'(relogin_win));
			end else begin
				// first free slot, else oldest unpinned stamp (plain compare), else slot 0
				victim = -1;
				for (int i = stlr_pkg::SLOTS - 1; i >= 0; i--) begin
					if (!tracked_active[i]) begin
						victim = i;
					end
				end
				if (victim < 0) begin
					for (int i = 0; i < stlr_pkg::SLOTS; i++) begin
						if (!tracked_sysop[i] &&
						    (victim < 0 || tracked_seen[i] < tracked_seen[victim])) begin
							victim = i;
						end
					end
				end
				if (victim < 0) begin
					victim = 0;
				end
				found = victim;
				r.evicted = tracked_active[found];
				tracked_key[found] = key;
				tracked_active[found] = 1'b1;
				tracked_sysop[found] = 1'b0;
			end
			tracked_seen[found] = now;
			if (admin) begin
				tracked_sysop[found] = 1'b1;
			end
			tracked_registered[found] = known;
			r.slot = stlr_pkg::OUT_SLOT_W'(found);
		end
		// count online registered sessions after the update
		online = 0;
		for (int i = 0; i < stlr_pkg::SLOTS; i++) begin
			age = now - tracked_seen[i];
			if (tracked_active[i] && tracked_registered[i] &&
			    age <= stlr_pkg::TS_W'(online_win)) begin
				online++;
			end
		end
		if (online > 15) begin
			online = 15;
		end
		r.online_count = stlr_pkg::OUT_COUNT_W'(online);
		return r;
	endfunction

	function automatic int field_differs(input string field, input logic [7:0] want,
	                                     input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// follow register writes, predict on each request transfer, compare each response
	always @(posedge clk or negedge arst_n) begin : track
		session_result_t want;
		session_result_t got;
		int              bad;
		if (!arst_n) begin
			for (int i = 0; i < stlr_pkg::SLOTS; i++) begin
				tracked_key[i] = '0;
				tracked_active[i] = 1'b0;
				tracked_sysop[i] = 1'b0;
				tracked_registered[i] = 1'b0;
				tracked_seen[i] = '0;
			end
			online_win = stlr_pkg::ONLINE_WIN_RST;
			relogin_win = stlr_pkg::RELOGIN_WIN_RST;
			expected_results.delete();
			failures <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == stlr_pkg::REG_ONLINE_WIN) begin
					online_win = pwdata[stlr_pkg::WIN_W-1:0];
				end else begin
					relogin_win = pwdata[stlr_pkg::WIN_W-1:0];
				end
			end
			if (rsp.valid && rsp.ready) begin
				got = {rsp.slot, rsp.hit, rsp.evicted, rsp.fast_rejoin, rsp.online_count};
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %p",
					         $time, got);
					bad++;
				end else begin
					want = expected_results.pop_front();
					bad += field_differs("slot", 8'(want.slot), 8'(got.slot));
					bad += field_differs("hit", 8'(want.hit), 8'(got.hit));
					bad += field_differs("evicted", 8'(want.evicted), 8'(got.evicted));
					bad += field_differs("fast_rejoin", 8'(want.fast_rejoin),
					                     8'(got.fast_rejoin));
					bad += field_differs("online_count", 8'(want.online_count),
					                     8'(got.online_count));
				end
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(predict_session_update(req.mode, req.user_key,
					req.now_secs, req.admin, req.user_known));
			end
			failures <= failures + bad;
			outstanding <= expected_results.size();
		end
	end

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_CYCLES    = stlr_pkg::SLOTS + 3;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int POOL_SIZE      = 12;
	localparam int RX_HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int failures;
	int outstanding;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_asks = 0;
	int rx_hold_done = 0;
	int rx_hold_left = 0;

	logic [stlr_pkg::TS_W-1:0]     sim_now;
	logic [stlr_pkg::KEY_BITS-1:0] key_pool [POOL_SIZE];
	logic [stlr_pkg::KEY_BITS-1:0] dkey [12];

	stlr_req_if req ();
	stlr_rsp_if rsp ();

	session_table_lru_replace dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	session_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// response side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rsp.ready <= 1'b0;
			rx_hold_left = rx_hold_left - 1;
		end else if (rx_hold_done != rx_hold_asks) begin
			rsp.ready <= 1'b0;
			rx_hold_left = RX_HOLD_CYCLES - 1;
			rx_hold_done = rx_hold_asks;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// offer one item and hold it until the transfer
	task automatic send_item(input logic mode, input logic [stlr_pkg::KEY_BITS-1:0] key,
	                         input logic [stlr_pkg::TS_W-1:0] now, input logic admin,
	                         input logic known);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		req.valid <= 1'b1;
		req.mode <= mode;
		req.user_key <= key;
		req.now_secs <= now;
		req.admin <= admin;
		req.user_known <= known;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic drain(input int settle);
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(input logic reg_sel, input logic [stlr_pkg::WIN_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_windows(input logic [stlr_pkg::WIN_W-1:0] online,
	                           input logic [stlr_pkg::WIN_W-1:0] relogin);
		drain(2 * ITEM_CYCLES);
		write_register(stlr_pkg::REG_ONLINE_WIN, online);
		write_register(stlr_pkg::REG_RELOGIN_WIN, relogin);
	endtask

	// mostly accesses and releases over a small key pool, some noise
	task automatic run_sessions(input int count, input bit pressure);
		int                            pick;
		logic                          mode;
		logic [stlr_pkg::KEY_BITS-1:0] key;
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = {$urandom, $urandom};
		end
		for (int n = 0; n < count; n++) begin
			if (pressure && n == count / 3) begin
				rx_hold_asks = rx_hold_asks + 1;
			end
			if (pressure && n == (2 * count) / 3) begin
				drain(0);
			end
			pick = $urandom_range(99);
			if ($urandom_range(99) < 4) begin
				sim_now = $urandom;
			end else begin
				sim_now = sim_now + $urandom_range(0, 150);
			end
			key = key_pool[$urandom_range(POOL_SIZE - 1)];
			mode = stlr_pkg::MODE_ACCESS;
			if (pick < 5) begin
				key = {$urandom, $urandom};
				mode = 1'($urandom_range(1));
			end else if (pick < 20) begin
				mode = stlr_pkg::MODE_RELEASE;
			end
			send_item(mode, key, sim_now, $urandom_range(99) < 8, $urandom_range(99) < 75);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req.valid <= 1'b0;
		req.mode <= stlr_pkg::MODE_ACCESS;
		req.user_key <= '0;
		req.now_secs <= '0;
		req.admin <= 1'b0;
		req.user_known <= 1'b0;
		for (int i = 0; i < 12; i++) begin
			dkey[i] = {$urandom, $urandom};
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 34;
		rx_idle_pct = 84;

		// fill every slot with pinned sessions just below the stamp wrap
		send_item(stlr_pkg::MODE_ACCESS, '1, 32'hFFFF_FFF8, 1'b1, 1'b1);
		for (int i = 1; i < 8; i++) begin
			send_item(stlr_pkg::MODE_ACCESS, dkey[i], 32'hFFFF_FFF8 + i, 1'b1, i[0]);
		end
		// all pinned: slot 0 is replaced
		send_item(stlr_pkg::MODE_ACCESS, '0, 32'd0, 1'b0, 1'b1);
		// quick relogin, release, release of an unknown key
		send_item(stlr_pkg::MODE_ACCESS, '0, 32'd5, 1'b0, 1'b1);
		send_item(stlr_pkg::MODE_RELEASE, '0, 32'd6, 1'b0, 1'b0);
		send_item(stlr_pkg::MODE_RELEASE, '0, 32'd7, 1'b1, 1'b1);
		send_item(stlr_pkg::MODE_ACCESS, '0, 32'd10, 1'b0, 1'b0);
		send_item(stlr_pkg::MODE_RELEASE, dkey[3], 32'd11, 1'b0, 1'b0);
		// stamps compare as plain values: the pre-wrap stamp looks newest
		send_item(stlr_pkg::MODE_ACCESS, dkey[8], 32'hFFFF_FFF0, 1'b0, 1'b1);
		send_item(stlr_pkg::MODE_ACCESS, dkey[9], 32'd20, 1'b0, 1'b1);
		// equal stamps: lowest index goes first
		send_item(stlr_pkg::MODE_RELEASE, dkey[1], 32'd30, 1'b0, 1'b0);
		send_item(stlr_pkg::MODE_RELEASE, dkey[2], 32'd30, 1'b0, 1'b0);
		send_item(stlr_pkg::MODE_ACCESS, dkey[10], 32'd100, 1'b0, 1'b1);
		send_item(stlr_pkg::MODE_ACCESS, dkey[11], 32'd100, 1'b0, 1'b0);
		send_item(stlr_pkg::MODE_ACCESS, dkey[9], 32'd200, 1'b0, 1'b0);
		send_item(stlr_pkg::MODE_ACCESS, '0, 32'd300, 1'b0, 1'b1);
		// hit on an unregistered slot, pin it
		send_item(stlr_pkg::MODE_ACCESS, dkey[11], 32'd310, 1'b1, 1'b1);
		// relogin window edges
		send_item(stlr_pkg::MODE_ACCESS, dkey[5], 32'd320, 1'b0, 1'b1);
		send_item(stlr_pkg::MODE_ACCESS, dkey[5], 32'd379, 1'b0, 1'b1);
		send_item(stlr_pkg::MODE_ACCESS, dkey[5], 32'd439, 1'b0, 1'b1);

		sim_now = $urandom;
		set_windows('0, '0);
		run_sessions(280, 1'b0);

		tx_idle_pct = 84;
		rx_idle_pct = 34;
		set_windows('1, '1);
		run_sessions(280, 1'b1);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_windows(stlr_pkg::WIN_W'($urandom_range(100, 2000)),
		            stlr_pkg::WIN_W'($urandom_range(10, 300)));
		run_sessions(290, 1'b0);

		drain(2 * ITEM_CYCLES);
		if (failures == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
design/stlr_pkg.sv
design/stlr_ifs.sv
design/stlr_ram.sv
design/session_table_lru_replace.sv
tb/session_checker.sv
tb/tb.sv
